// File: hdl/acie_pkg.sv
// Shared types, constants and microprogram for the ARP cache insert/expire core.
// Used by acie_seq, acie_table and arp_cache_insert_expire_core; no dependencies.
package acie_pkg;

    localparam int KEY_W       = 32;
    localparam int MAC_W       = 48;
    localparam int TIME_W      = 32;
    localparam int LIMIT_W     = 7;
    localparam int CNT_OUT_W   = 7;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd300;

    localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_LIMIT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT     = 1'd1;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_TIMER  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_NEW     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REFRESH = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SWEEP   = 2'd3;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [MAC_W-1:0]   mac;
        logic [TIME_W-1:0]  stamp;
    } entry_t;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t STEP_CLEAR     = 4'd0;
    localparam pc_t STEP_IDLE      = 4'd1;
    localparam pc_t STEP_DISPATCH  = 4'd2;
    localparam pc_t STEP_LOOKUP    = 4'd3;
    localparam pc_t STEP_CHECK_HIT = 4'd4;
    localparam pc_t STEP_CHECK_LIM = 4'd5;
    localparam pc_t STEP_SWEEP     = 4'd6;
    localparam pc_t STEP_INSERT    = 4'd7;
    localparam pc_t STEP_EMIT      = 4'd8;

    typedef logic [2:0] act_t;

    localparam act_t ACT_NONE       = 3'd0;
    localparam act_t ACT_CLEAR      = 3'd1;
    localparam act_t ACT_LOAD       = 3'd2;
    localparam act_t ACT_LOOKUP     = 3'd3;
    localparam act_t ACT_SCAN_RESET = 3'd4;
    localparam act_t ACT_SWEEP      = 3'd5;
    localparam act_t ACT_INSERT     = 3'd6;
    localparam act_t ACT_EMIT       = 3'd7;

    typedef logic [2:0] cond_t;

    localparam cond_t COND_ALWAYS      = 3'd0;
    localparam cond_t COND_CLEAR_RUN   = 3'd1;
    localparam cond_t COND_NO_ACCEPT   = 3'd2;
    localparam cond_t COND_OP_TIMER    = 3'd3;
    localparam cond_t COND_SCAN_RUN    = 3'd4;
    localparam cond_t COND_HIT         = 3'd5;
    localparam cond_t COND_UNDER_LIMIT = 3'd6;
    localparam cond_t COND_OUT_BLOCKED = 3'd7;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        pc_t   jump_pc;
        pc_t   next_pc;
    } ucode_t;

    typedef struct packed {
        logic clear_run;
        logic no_accept;
        logic op_timer;
        logic scan_run;
        logic hit;
        logic under_limit;
        logic out_blocked;
    } cond_flags_t;

    function automatic ucode_t ucode_rom(input pc_t pc);
        ucode_t w;
        w = '{ACT_NONE, COND_ALWAYS, STEP_IDLE, STEP_IDLE};
        unique case (pc)
            STEP_CLEAR:     w = '{ACT_CLEAR,      COND_CLEAR_RUN,   STEP_CLEAR,  STEP_IDLE};
            STEP_IDLE:      w = '{ACT_LOAD,       COND_NO_ACCEPT,   STEP_IDLE,   STEP_DISPATCH};
            STEP_DISPATCH:  w = '{ACT_NONE,       COND_OP_TIMER,    STEP_SWEEP,  STEP_LOOKUP};
            STEP_LOOKUP:    w = '{ACT_LOOKUP,     COND_SCAN_RUN,    STEP_LOOKUP, STEP_CHECK_HIT};
            STEP_CHECK_HIT: w = '{ACT_NONE,       COND_HIT,         STEP_EMIT,   STEP_CHECK_LIM};
            STEP_CHECK_LIM: w = '{ACT_SCAN_RESET, COND_UNDER_LIMIT, STEP_INSERT, STEP_SWEEP};
            STEP_SWEEP:     w = '{ACT_SWEEP,      COND_SCAN_RUN,    STEP_SWEEP,  STEP_INSERT};
            STEP_INSERT:    w = '{ACT_INSERT,     COND_ALWAYS,      STEP_EMIT,   STEP_EMIT};
            STEP_EMIT:      w = '{ACT_EMIT,       COND_OUT_BLOCKED, STEP_EMIT,   STEP_IDLE};
            default:        w = '{ACT_NONE,       COND_ALWAYS,      STEP_IDLE,   STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: hdl/arp_cache_insert_expire_core.sv
// ARP cache core: IPv4 key to MAC table with insert, refresh and timeout sweep.
// Timer words sweep the table; an insert looks the key up, refreshes it on a hit and else
// inserts, sweeping first when the entry limit would be exceeded. One word in flight; the
// next is accepted in the cycle out_valid rises; a stalled result holds the next back.
// Reset: rst_n asynchronous; a clearing pass follows, during which in_stall stays high.
// Registers reset to entry_limit 0, timeout_seconds 300.
module arp_cache_insert_expire_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  operation,
    input  logic [acie_pkg::KEY_W-1:0]            ip_address,
    input  logic [acie_pkg::MAC_W-1:0]            mac_address,
    input  logic [acie_pkg::TIME_W-1:0]           now_seconds,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [acie_pkg::STATUS_W-1:0]         status,
    output logic [acie_pkg::CNT_OUT_W-1:0]        expired_count,
    output logic [acie_pkg::CNT_OUT_W-1:0]        entry_count,
    input  logic                                  cfg_write,
    input  logic [acie_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [acie_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = ((CNT_W > acie_pkg::LIMIT_W) ? CNT_W : acie_pkg::LIMIT_W) + 1;

    acie_pkg::act_t        act;
    acie_pkg::cond_flags_t flags;

    logic                           wr_en;
    logic [IDX_W-1:0]               wr_addr;
    acie_pkg::entry_t               wr_data;
    logic                           rd_en;
    acie_pkg::entry_t               rd_data;

    logic [acie_pkg::LIMIT_W-1:0]   limit_reg;
    logic [acie_pkg::TIME_W-1:0]    timeout_reg;

    logic                           op_reg,      op_next;
    logic [acie_pkg::KEY_W-1:0]     ip_reg,      ip_next;
    logic [acie_pkg::MAC_W-1:0]     mac_reg,     mac_next;
    logic [acie_pkg::TIME_W-1:0]    now_reg,     now_next;
    logic [IDX_W-1:0]               clr_idx_reg, clr_idx_next;
    logic [CNT_W-1:0]               rd_idx_reg,  rd_idx_next;
    logic                           chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]               chk_idx_reg, chk_idx_next;
    logic                           hit_reg,     hit_next;
    logic                           free_found_reg, free_found_next;
    logic [IDX_W-1:0]               free_idx_reg, free_idx_next;
    logic [CNT_W-1:0]               removed_reg, removed_next;
    logic [CNT_W-1:0]               live_reg,    live_next;
    logic                           ins_ok_reg,  ins_ok_next;
    logic                           out_vld_reg, out_vld_next;
    logic [acie_pkg::STATUS_W-1:0]  status_reg,  status_next;
    logic [acie_pkg::CNT_OUT_W-1:0] exp_out_reg, exp_out_next;
    logic [acie_pkg::CNT_OUT_W-1:0] cnt_out_reg, cnt_out_next;

    logic                           issue;
    logic                           key_hit;
    logic                           expired;
    logic                           sweep_free;
    logic [CMP_W-1:0]               limit_ext;
    logic [CMP_W-1:0]               depth_ext;
    logic [CMP_W-1:0]               eff_limit;
    logic [CMP_W-1:0]               live_ext;
    logic [CMP_W-1:0]               removed_ext;

    acie_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .act   (act)
    );

    acie_table #(
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign in_stall      = (act != acie_pkg::ACT_LOAD);
    assign out_valid     = out_vld_reg;
    assign status        = status_reg;
    assign expired_count = exp_out_reg;
    assign entry_count   = cnt_out_reg;

    assign issue = ((act == acie_pkg::ACT_LOOKUP) || (act == acie_pkg::ACT_SWEEP)) &&
                   (rd_idx_reg < CNT_W'(TABLE_DEPTH)) && !hit_reg;
    assign rd_en = issue;

    assign key_hit    = rd_data.valid && (rd_data.key == ip_reg);
    assign expired    = rd_data.valid &&
                        (({1'b0, rd_data.stamp} + {1'b0, timeout_reg}) < {1'b0, now_reg});
    assign sweep_free = (!rd_data.valid || expired) &&
                        (!free_found_reg || (chk_idx_reg < free_idx_reg));

    assign limit_ext   = CMP_W'(limit_reg);
    assign depth_ext   = CMP_W'(TABLE_DEPTH);
    assign eff_limit   = ((limit_reg == '0) || (limit_ext > depth_ext)) ? depth_ext : limit_ext;
    assign live_ext    = CMP_W'(live_reg);
    assign removed_ext = CMP_W'(removed_reg);

    always_comb
    begin
        flags.clear_run   = (clr_idx_reg != IDX_W'(TABLE_DEPTH - 1));
        flags.no_accept   = !in_valid;
        flags.op_timer    = (op_reg == acie_pkg::OP_TIMER);
        flags.scan_run    = !(hit_reg || ((rd_idx_reg == CNT_W'(TABLE_DEPTH)) && !chk_vld_reg));
        flags.hit         = hit_reg;
        flags.under_limit = ((live_ext + CMP_W'(1)) <= eff_limit);
        flags.out_blocked = out_vld_reg && out_stall;
    end

    // memory write port
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = chk_idx_reg;
        wr_data = rd_data;
        unique case (act)
            acie_pkg::ACT_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_idx_reg;
                wr_data = '0;
            end
            acie_pkg::ACT_LOOKUP:
            begin
                if (chk_vld_reg && !hit_reg && key_hit)
                begin
                    wr_en     = 1'b1;
                    wr_data   = '{1'b1, rd_data.key, mac_reg, now_reg};
                end
            end
            acie_pkg::ACT_SWEEP:
            begin
                if (chk_vld_reg && expired)
                begin
                    wr_en         = 1'b1;
                    wr_data.valid = 1'b0;
                end
            end
            acie_pkg::ACT_INSERT:
            begin
                if ((op_reg == acie_pkg::OP_INSERT) && free_found_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = free_idx_reg;
                    wr_data = '{1'b1, ip_reg, mac_reg, now_reg};
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        op_next         = op_reg;
        ip_next         = ip_reg;
        mac_next        = mac_reg;
        now_next        = now_reg;
        clr_idx_next    = clr_idx_reg;
        rd_idx_next     = rd_idx_reg;
        chk_vld_next    = issue;
        chk_idx_next    = rd_idx_reg[IDX_W-1:0];
        hit_next        = hit_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        removed_next    = removed_reg;
        live_next       = live_reg;
        ins_ok_next     = ins_ok_reg;
        out_vld_next    = out_vld_reg;
        status_next     = status_reg;
        exp_out_next    = exp_out_reg;
        cnt_out_next    = cnt_out_reg;

        if (out_vld_reg && !out_stall)
        begin
            out_vld_next = 1'b0;
        end

        if (issue)
        begin
            rd_idx_next = rd_idx_reg + CNT_W'(1);
        end

        unique case (act)
            acie_pkg::ACT_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + IDX_W'(1);
            end
            acie_pkg::ACT_LOAD:
            begin
                if (in_valid)
                begin
                    op_next         = operation;
                    ip_next         = ip_address;
                    mac_next        = mac_address;
                    now_next        = now_seconds;
                    rd_idx_next     = '0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    removed_next    = '0;
                    ins_ok_next     = 1'b0;
                end
            end
            acie_pkg::ACT_LOOKUP:
            begin
                if (chk_vld_reg && !hit_reg)
                begin
                    if (key_hit)
                    begin
                        hit_next = 1'b1;
                    end
                    else if (!rd_data.valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = chk_idx_reg;
                    end
                end
            end
            acie_pkg::ACT_SCAN_RESET:
            begin
                rd_idx_next = '0;
            end
            acie_pkg::ACT_SWEEP:
            begin
                if (chk_vld_reg)
                begin
                    if (expired)
                    begin
                        removed_next = removed_reg + CNT_W'(1);
                        live_next    = live_reg - CNT_W'(1);
                    end
                    if (sweep_free)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = chk_idx_reg;
                    end
                end
            end
            acie_pkg::ACT_INSERT:
            begin
                if ((op_reg == acie_pkg::OP_INSERT) && free_found_reg)
                begin
                    live_next   = live_reg + CNT_W'(1);
                    ins_ok_next = 1'b1;
                end
            end
            acie_pkg::ACT_EMIT:
            begin
                if (!(out_vld_reg && out_stall))
                begin
                    out_vld_next = 1'b1;
                    exp_out_next = removed_ext[acie_pkg::CNT_OUT_W-1:0];
                    cnt_out_next = live_ext[acie_pkg::CNT_OUT_W-1:0];
                    priority if (op_reg == acie_pkg::OP_TIMER)
                        status_next = acie_pkg::ST_SWEEP;
                    else if (hit_reg)
                        status_next = acie_pkg::ST_REFRESH;
                    else if (ins_ok_reg)
                        status_next = acie_pkg::ST_NEW;
                    else
                        status_next = acie_pkg::ST_FULL;
                end
            end
            default:
            begin
                clr_idx_next = clr_idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg      <= '0;
            timeout_reg    <= acie_pkg::TIMEOUT_RESET;
            clr_idx_reg    <= '0;
            rd_idx_reg     <= '0;
            chk_vld_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            removed_reg    <= '0;
            live_reg       <= '0;
            ins_ok_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            op_reg         <= acie_pkg::OP_INSERT;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    acie_pkg::REG_ENTRY_LIMIT: limit_reg   <= cfg_data[acie_pkg::LIMIT_W-1:0];
                    acie_pkg::REG_TIMEOUT:     timeout_reg <= cfg_data[acie_pkg::TIME_W-1:0];
                endcase
            end
            clr_idx_reg    <= clr_idx_next;
            rd_idx_reg     <= rd_idx_next;
            chk_vld_reg    <= chk_vld_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
            removed_reg    <= removed_next;
            live_reg       <= live_next;
            ins_ok_reg     <= ins_ok_next;
            out_vld_reg    <= out_vld_next;
            op_reg         <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ip_reg       <= ip_next;
        mac_reg      <= mac_next;
        now_reg      <= now_next;
        chk_idx_reg  <= chk_idx_next;
        free_idx_reg <= free_idx_next;
        status_reg   <= status_next;
        exp_out_reg  <= exp_out_next;
        cnt_out_reg  <= cnt_out_next;
    end

endmodule

// File: hdl/acie_seq.sv
// Microcode sequencer: step counter, program ROM lookup and conditional jump.
// Depends on acie_pkg.
module acie_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  acie_pkg::cond_flags_t flags,
    output acie_pkg::act_t        act
);

    acie_pkg::pc_t    pc_reg;
    acie_pkg::pc_t    pc_next;
    acie_pkg::ucode_t word;
    logic             take;

    assign word = acie_pkg::ucode_rom(pc_reg);
    assign act  = word.act;

    always_comb
    begin
        unique case (word.cond)
            acie_pkg::COND_ALWAYS:      take = 1'b1;
            acie_pkg::COND_CLEAR_RUN:   take = flags.clear_run;
            acie_pkg::COND_NO_ACCEPT:   take = flags.no_accept;
            acie_pkg::COND_OP_TIMER:    take = flags.op_timer;
            acie_pkg::COND_SCAN_RUN:    take = flags.scan_run;
            acie_pkg::COND_HIT:         take = flags.hit;
            acie_pkg::COND_UNDER_LIMIT: take = flags.under_limit;
            acie_pkg::COND_OUT_BLOCKED: take = flags.out_blocked;
        endcase
        pc_next = take ? word.jump_pc : word.next_pc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= acie_pkg::STEP_CLEAR;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// File: hdl/acie_table.sv
// Slot memory: one entry word per slot, one write and one registered read per cycle.
// Depends on acie_pkg.
module acie_table #(
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  acie_pkg::entry_t         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output acie_pkg::entry_t         rd_data
);

    acie_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: tb/sv/arp_cache_insert_expire_core_test.sv
// Self-checking testbench for arp_cache_insert_expire_core: directed, table-fill and random
// traffic checked against an in-bench model of the cache. Depends on acie_pkg and the core.
module arp_cache_insert_expire_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 64;
    localparam int QUIET_CYCLES = 2 * DEPTH + 40;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASE_WORDS  = 160;
    localparam int REPLY_SLOTS  = 16;

    typedef struct packed {
        logic [acie_pkg::STATUS_W-1:0]  status;
        logic [acie_pkg::CNT_OUT_W-1:0] expired;
        logic [acie_pkg::CNT_OUT_W-1:0] live;
    } reply_t;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    logic                             operation;
    logic [acie_pkg::KEY_W-1:0]       ip_address;
    logic [acie_pkg::MAC_W-1:0]       mac_address;
    logic [acie_pkg::TIME_W-1:0]      now_seconds;
    logic                             out_valid;
    logic                             out_stall;
    logic [acie_pkg::STATUS_W-1:0]    status;
    logic [acie_pkg::CNT_OUT_W-1:0]   expired_count;
    logic [acie_pkg::CNT_OUT_W-1:0]   entry_count;
    logic                             cfg_write;
    logic [acie_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [acie_pkg::CFG_DATA_W-1:0]  cfg_data;

    // cache model
    logic                          cache_valid [DEPTH];
    logic [acie_pkg::KEY_W-1:0]    cache_key   [DEPTH];
    logic [acie_pkg::MAC_W-1:0]    cache_mac   [DEPTH];
    logic [acie_pkg::TIME_W-1:0]   cache_stamp [DEPTH];
    int unsigned                   cache_live;
    logic [acie_pkg::LIMIT_W-1:0]  limit_reg;
    logic [acie_pkg::TIME_W-1:0]   timeout_reg;

    reply_t      reply_store [REPLY_SLOTS];
    int unsigned replies_queued;
    int unsigned replies_taken;
    reply_t      expected_reply;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned mismatch_count;
    int unsigned words_sent;
    int unsigned results_checked;
    int unsigned status_seen [4];
    int unsigned cycle_count;
    logic [acie_pkg::TIME_W-1:0] clock_now;
    logic [acie_pkg::KEY_W-1:0]  pool_base;

    arp_cache_insert_expire_core #(
        .TABLE_DEPTH(DEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .ip_address   (ip_address),
        .mac_address  (mac_address),
        .now_seconds  (now_seconds),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .expired_count(expired_count),
        .entry_count  (entry_count),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     replies_queued - replies_taken);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int unsigned expire_stale(input logic [acie_pkg::TIME_W-1:0] now);
        int unsigned removed;
        removed = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (cache_valid[i] &&
                ({1'b0, cache_stamp[i]} + {1'b0, timeout_reg} < {1'b0, now}))
            begin
                cache_valid[i] = 1'b0;
                removed++;
            end
        end
        cache_live -= removed;
        return removed;
    endfunction

    function automatic reply_t predict_reply(input logic op,
                                             input logic [acie_pkg::KEY_W-1:0] ip,
                                             input logic [acie_pkg::MAC_W-1:0] mac,
                                             input logic [acie_pkg::TIME_W-1:0] now);
        reply_t      r;
        int unsigned removed;
        int unsigned cap;
        int          hit_slot;
        int          free_slot;
        removed   = 0;
        hit_slot  = -1;
        free_slot = -1;
        if (op == acie_pkg::OP_TIMER)
        begin
            removed  = expire_stale(now);
            r.status = acie_pkg::ST_SWEEP;
        end
        else
        begin
            for (int i = 0; i < DEPTH; i++)
                if (hit_slot < 0 && cache_valid[i] && cache_key[i] == ip)
                    hit_slot = i;
            if (hit_slot >= 0)
            begin
                cache_mac[hit_slot]   = mac;
                cache_stamp[hit_slot] = now;
                r.status = acie_pkg::ST_REFRESH;
            end
            else
            begin
                cap = (limit_reg == 0 || limit_reg > DEPTH) ? DEPTH : limit_reg;
                if (cache_live + 1 > cap)
                    removed = expire_stale(now);
                for (int i = 0; i < DEPTH; i++)
                    if (free_slot < 0 && !cache_valid[i])
                        free_slot = i;
                if (free_slot < 0)
                    r.status = acie_pkg::ST_FULL;
                else
                begin
                    cache_valid[free_slot] = 1'b1;
                    cache_key[free_slot]   = ip;
                    cache_mac[free_slot]   = mac;
                    cache_stamp[free_slot] = now;
                    cache_live++;
                    r.status = acie_pkg::ST_NEW;
                end
            end
        end
        r.expired = acie_pkg::CNT_OUT_W'(removed);
        r.live    = acie_pkg::CNT_OUT_W'(cache_live);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s: got %0d, expected %0d (result %0d, %0t)", field, got, want,
                 results_checked, $realtime);
        mismatch_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (replies_queued == replies_taken)
                report_mismatch("unexpected word", 32'(status), 0);
            else
            begin
                expected_reply = reply_store[replies_taken % REPLY_SLOTS];
                replies_taken++;
                if (status !== expected_reply.status)
                    report_mismatch("status", 32'(status), 32'(expected_reply.status));
                if (expired_count !== expected_reply.expired)
                    report_mismatch("expired_count", 32'(expired_count),
                                    32'(expected_reply.expired));
                if (entry_count !== expected_reply.live)
                    report_mismatch("entry_count", 32'(entry_count), 32'(expected_reply.live));
                status_seen[expected_reply.status]++;
                results_checked++;
            end
        end
    end

    always @(negedge clk)
        out_stall = (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);

    task automatic send_word(input logic op, input logic [acie_pkg::KEY_W-1:0] ip,
                             input logic [acie_pkg::MAC_W-1:0] mac,
                             input logic [acie_pkg::TIME_W-1:0] now);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid    = 1'b1;
        operation   = op;
        ip_address  = ip;
        mac_address = mac;
        now_seconds = now;
        do
            @(posedge clk);
        while (in_stall);
        reply_store[replies_queued % REPLY_SLOTS] = predict_reply(op, ip, mac, now);
        replies_queued++;
        words_sent++;
        @(negedge clk);
    endtask

    task automatic settle_block();
        in_valid = 1'b0;
        while (replies_queued != replies_taken)
            @(negedge clk);
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [acie_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [acie_pkg::CFG_DATA_W-1:0] data);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_write = 1'b0;
        if (idx == acie_pkg::REG_ENTRY_LIMIT)
            limit_reg = data[acie_pkg::LIMIT_W-1:0];
        else
            timeout_reg = data;
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    task automatic test_directed();
        // reset settings: whole table, 300 s lifetime
        send_word(acie_pkg::OP_INSERT, 32'h0000_0000, 48'h0, 32'd0);
        send_word(acie_pkg::OP_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_word(acie_pkg::OP_INSERT, 32'h0000_0000, 48'h0123_4567_89AB, 32'd10);
        // stamp in the future is kept, then the boundary of the lifetime
        send_word(acie_pkg::OP_TIMER, 32'hDEAD_BEEF, 48'hA5A5_5A5A_A5A5, 32'd0);
        send_word(acie_pkg::OP_TIMER, 32'h0, 48'h0, 32'd310);
        send_word(acie_pkg::OP_TIMER, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'd311);
        settle_block();
        write_reg(acie_pkg::REG_ENTRY_LIMIT, 32'd1);
        write_reg(acie_pkg::REG_TIMEOUT, 32'd5);
        // over the limit: sweep first, new entry still goes in
        send_word(acie_pkg::OP_INSERT, 32'h0000_0001, 48'h0000_0000_0001, 32'd100);
        send_word(acie_pkg::OP_INSERT, 32'h0000_0002, 48'h8000_0000_0000, 32'd200);
        send_word(acie_pkg::OP_INSERT, 32'h0000_0002, 48'h7FFF_FFFF_FFFF, 32'd900);
        send_word(acie_pkg::OP_TIMER, 32'h0, 48'h0, 32'hFFFF_FFFF);
        settle_block();
        // limit beyond the table acts as the whole table
        write_reg(acie_pkg::REG_ENTRY_LIMIT, 32'd100);
        write_reg(acie_pkg::REG_TIMEOUT, 32'd0);
        send_word(acie_pkg::OP_INSERT, 32'h0000_0003, 48'h5555_5555_5555, 32'd7);
        send_word(acie_pkg::OP_INSERT, 32'h8000_0000, 48'hAAAA_AAAA_AAAA, 32'd8);
        send_word(acie_pkg::OP_TIMER, 32'h0, 48'h0, 32'd8);
        send_word(acie_pkg::OP_TIMER, 32'h0, 48'h0, 32'd9);
        settle_block();
    endtask

    task automatic test_table_full();
        write_reg(acie_pkg::REG_ENTRY_LIMIT, 32'd0);
        write_reg(acie_pkg::REG_TIMEOUT, 32'hFFFF_FFFF);
        for (int i = 0; i < DEPTH + 2; i++)
            send_word(acie_pkg::OP_INSERT, 32'h0A00_0000 + i,
                      acie_pkg::MAC_W'({$urandom(), $urandom()}), 32'd1000 + i);
        send_word(acie_pkg::OP_INSERT, 32'h0A00_0005, 48'h0000_FFFF_0000, 32'd5000);
        settle_block();
        write_reg(acie_pkg::REG_TIMEOUT, 32'd0);
        send_word(acie_pkg::OP_TIMER, 32'h0, 48'h0, 32'hFFFF_FFFF);
        settle_block();
    endtask

    task automatic run_traffic(input int count);
        logic                       op;
        logic [acie_pkg::KEY_W-1:0] ip;
        logic [acie_pkg::MAC_W-1:0] mac;
        for (int k = 0; k < count; k++)
        begin
            op  = ($urandom_range(7) == 0) ? acie_pkg::OP_TIMER : acie_pkg::OP_INSERT;
            ip  = ($urandom_range(3) == 0) ? $urandom() : pool_base + $urandom_range(79);
            mac = acie_pkg::MAC_W'({$urandom(), $urandom()});
            if ($urandom_range(15) == 0)
                clock_now = $urandom();
            else
                clock_now = clock_now + $urandom_range(40);
            send_word(op, ip, mac, clock_now);
        end
    endtask

    task automatic test_random_phases();
        logic [acie_pkg::LIMIT_W-1:0] limits   [7] = '{7'd0, 7'd1, 7'd64, 7'd100, 7'd8,
                                                      7'd127, 7'd63};
        logic [acie_pkg::TIME_W-1:0]  timeouts [7] = '{32'd300, 32'd0, 32'hFFFF_FFFF, 32'd50,
                                                      32'd30, 32'd1000, 32'd5};
        for (int p = 0; p < 7; p++)
        begin
            if (p < 3)
                set_idling(20, 77);
            else if (p < 5)
                set_idling(77, 20);
            else
                set_idling(0, 0);
            write_reg(acie_pkg::REG_ENTRY_LIMIT, acie_pkg::CFG_DATA_W'(limits[p]));
            write_reg(acie_pkg::REG_TIMEOUT, timeouts[p]);
            pool_base = $urandom();
            clock_now = $urandom();
            run_traffic(PHASE_WORDS);
            settle_block();
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        operation      = acie_pkg::OP_INSERT;
        ip_address     = '0;
        mac_address    = '0;
        now_seconds    = '0;
        out_stall      = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = acie_pkg::REG_ENTRY_LIMIT;
        cfg_data       = '0;
        mismatch_count = 0;
        words_sent     = 0;
        results_checked = 0;
        replies_queued = 0;
        replies_taken  = 0;
        cycle_count    = 0;
        status_seen    = '{0, 0, 0, 0};
        clock_now      = '0;
        pool_base      = '0;
        for (int i = 0; i < DEPTH; i++)
            cache_valid[i] = 1'b0;
        cache_live  = 0;
        limit_reg   = '0;
        timeout_reg = acie_pkg::TIMEOUT_RESET;
        set_idling(20, 77);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        settle_block();

        test_directed();
        test_table_full();
        test_random_phases();
        settle_block();

        $display("%0d words sent, %0d results checked, %0d mismatches",
                 words_sent, results_checked, mismatch_count);
        $display("results by kind: new %0d, refreshed %0d, full %0d, sweep %0d",
                 status_seen[acie_pkg::ST_NEW], status_seen[acie_pkg::ST_REFRESH],
                 status_seen[acie_pkg::ST_FULL], status_seen[acie_pkg::ST_SWEEP]);
        if (mismatch_count == 0 && replies_queued == replies_taken)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
